### rtl/mgsrl_pkg.sv
// Shared constants and controller/datapath interface types for the mic gain level meter.
package mgsrl_pkg;

    // Field and state widths.
    localparam int RAW_W   = 32;
    localparam int PCM_W   = 16;
    localparam int LEVEL_W = 7;
    localparam int SHIFT_W = 5;
    localparam int GAIN_W  = 16;
    localparam int SUM_W   = 38;
    localparam int CNT_W   = 8;
    localparam int THR_W   = 42;
    localparam int CFG_W   = 16;

    // Block and level limits.
    localparam int MAX_FRAMES   = 128;
    localparam int LEVEL_MAX    = 100;
    localparam int LEVEL_UNIT2  = 1000000;
    localparam int SHIFT_MAX    = 24;
    localparam int GAIN_MAX     = 32768;
    localparam int SHIFT_RESET  = 8;
    localparam int GAIN_RESET   = 3277;
    localparam int GAIN_FRAC    = 14;

    // Configuration register indexes.
    typedef enum logic
    {
        REG_SHIFT = 1'b0,
        REG_GAIN  = 1'b1
    } cfg_index_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load_in;
        logic do_scale;
        logic do_sat;
        logic do_square;
        logic do_acc;
        logic do_prep;
        logic do_step;
        logic do_emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic block_done;
        logic search_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

### rtl/mgsrl_ctrl.sv
// Sequencing state machine for the mic gain level meter.
module mgsrl_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  mgsrl_pkg::ctrl_stat_t  stat,
    output logic                   in_ready,
    output mgsrl_pkg::ctrl_cmd_t   cmd
);
    import mgsrl_pkg::*;

    typedef enum logic [7:0]
    {
        S_IDLE   = 8'b0000_0001,
        S_SCALE  = 8'b0000_0010,
        S_SAT    = 8'b0000_0100,
        S_SQUARE = 8'b0000_1000,
        S_ACC    = 8'b0001_0000,
        S_PREP   = 8'b0010_0000,
        S_SEARCH = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:  state_next = S_SAT;
            S_SAT:    state_next = S_SQUARE;
            S_SQUARE: state_next = S_ACC;
            S_ACC:    state_next = stat.block_done ? S_PREP : S_EMIT;
            S_PREP:   state_next = S_SEARCH;
            S_SEARCH:
            begin
                if (stat.search_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    assign in_ready      = (state_reg == S_IDLE);
    assign cmd.load_in   = (state_reg == S_IDLE) && in_valid;
    assign cmd.do_scale  = (state_reg == S_SCALE);
    assign cmd.do_sat    = (state_reg == S_SAT);
    assign cmd.do_square = (state_reg == S_SQUARE);
    assign cmd.do_acc    = (state_reg == S_ACC);
    assign cmd.do_prep   = (state_reg == S_PREP);
    assign cmd.do_step   = (state_reg == S_SEARCH);
    assign cmd.do_emit   = (state_reg == S_EMIT) && stat.out_free;

endmodule

### rtl/mgsrl_dp.sv
// Datapath for the mic gain level meter: gain, saturation, square sum and level search.
module mgsrl_dp
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mgsrl_pkg::ctrl_cmd_t                    cmd,
    output mgsrl_pkg::ctrl_stat_t                   stat,
    input  logic                                    cfg_wen,
    input  logic                                    cfg_index,
    input  logic [mgsrl_pkg::CFG_W-1:0]             cfg_data,
    input  logic signed [mgsrl_pkg::RAW_W-1:0]      mic_sample,
    input  logic                                    block_end,
    output logic signed [mgsrl_pkg::PCM_W-1:0]      pcm_sample,
    output logic                                    level_valid,
    output logic [mgsrl_pkg::LEVEL_W-1:0]           sound_level,
    output logic                                    out_valid,
    input  logic                                    out_ready
);
    import mgsrl_pkg::*;

    localparam int PROD_W = RAW_W + GAIN_W + 1;
    localparam int UNIT_W = CNT_W + 20;

    logic [SHIFT_W-1:0]       shift_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [RAW_W-1:0]  raw_reg;
    logic                     end_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PCM_W-1:0]  pcm_reg;
    logic [2*PCM_W-1:0]       sq_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SUM_W-1:0]         blk_sum_reg;
    logic [CNT_W-1:0]         blk_cnt_reg;
    logic                     close_reg;
    logic [THR_W-1:0]         unit_reg;
    logic [THR_W-1:0]         thr_reg;
    logic [THR_W-1:0]         delta_reg;
    logic [LEVEL_W-1:0]       lvl_reg;
    logic signed [PCM_W-1:0]  out_pcm_reg;
    logic                     out_last_reg;
    logic [LEVEL_W-1:0]       out_lvl_reg;
    logic                     out_valid_reg;

    logic signed [RAW_W-1:0]  shifted;
    logic signed [PROD_W-1:0] shifted_ext;
    logic signed [PROD_W-1:0] gain_ext;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_neg;
    logic [PROD_W-1:0]        prod_abs;
    logic [PROD_W-GAIN_FRAC-1:0] mag;
    logic signed [PCM_W-1:0]  pcm_next;
    logic signed [2*PCM_W-1:0] sq_next;
    logic [SUM_W-1:0]         sum_acc;
    logic [CNT_W-1:0]         cnt_acc;
    logic                     end_now;
    logic [THR_W-1:0]         unit_next;
    logic                     step_ok;

    // Configuration writes; out-of-range values are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_W'(SHIFT_RESET);
            gain_reg  <= GAIN_W'(GAIN_RESET);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SHIFT:
                begin
                    if (cfg_data[SHIFT_W-1:0] <= SHIFT_W'(SHIFT_MAX))
                    begin
                        shift_reg <= cfg_data[SHIFT_W-1:0];
                    end
                end
                REG_GAIN:
                begin
                    if (cfg_data[GAIN_W-1:0] <= GAIN_W'(GAIN_MAX))
                    begin
                        gain_reg <= cfg_data[GAIN_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Arithmetic shift and gain multiply.
    assign shifted     = raw_reg >>> shift_reg;
    assign shifted_ext = PROD_W'(shifted);
    assign gain_ext    = $signed({{(PROD_W-GAIN_W){1'b0}}, gain_reg});
    assign prod_next   = shifted_ext * gain_ext;

    // Truncate toward zero and saturate to 16 bits.
    assign prod_neg = prod_reg[PROD_W-1];
    assign prod_abs = prod_neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign mag      = prod_abs[PROD_W-1:GAIN_FRAC];

    always_comb
    begin
        if (prod_neg)
        begin
            if (mag > (PROD_W-GAIN_FRAC)'(32768))
            begin
                pcm_next = -16'sd32768;
            end
            else
            begin
                pcm_next = PCM_W'(-$signed({1'b0, mag[PCM_W-1:0]}));
            end
        end
        else
        begin
            if (mag > (PROD_W-GAIN_FRAC)'(32767))
            begin
                pcm_next = 16'sd32767;
            end
            else
            begin
                pcm_next = $signed(mag[PCM_W-1:0]);
            end
        end
    end

    // Square and accumulate.
    assign sq_next = pcm_reg * pcm_reg;
    assign sum_acc = sum_reg + SUM_W'(sq_reg);
    assign cnt_acc = cnt_reg + CNT_W'(1);
    assign end_now = end_reg || (cnt_acc >= CNT_W'(MAX_FRAMES));

    // Level search: threshold for level L is count*1e6*L^2, stepped by odd multiples.
    assign unit_next = THR_W'(UNIT_W'(blk_cnt_reg) * UNIT_W'(LEVEL_UNIT2));
    assign step_ok   = (THR_W'(blk_sum_reg) >= thr_reg) && (lvl_reg != LEVEL_W'(LEVEL_MAX));

    // Per-item pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg <= mic_sample;
            end_reg <= block_end;
        end
        if (cmd.do_scale)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.do_sat)
        begin
            pcm_reg <= pcm_next;
        end
        if (cmd.do_square)
        begin
            sq_reg <= sq_next;
        end
        if (cmd.do_acc)
        begin
            blk_sum_reg <= sum_acc;
            blk_cnt_reg <= cnt_acc;
            close_reg   <= end_now;
            lvl_reg     <= '0;
        end
        if (cmd.do_prep)
        begin
            unit_reg  <= unit_next;
            thr_reg   <= unit_next;
            delta_reg <= unit_next + (unit_next << 1);
        end
        if (cmd.do_step && step_ok)
        begin
            lvl_reg   <= lvl_reg + LEVEL_W'(1);
            thr_reg   <= thr_reg + delta_reg;
            delta_reg <= delta_reg + (unit_reg << 1);
        end
        if (cmd.do_emit)
        begin
            out_pcm_reg  <= pcm_reg;
            out_last_reg <= close_reg;
            out_lvl_reg  <= lvl_reg;
        end
    end

    // Running block sum and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.do_acc)
        begin
            if (end_now)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_acc;
                cnt_reg <= cnt_acc;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.block_done  = end_now;
    assign stat.search_done = !step_ok;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign pcm_sample  = out_pcm_reg;
    assign level_valid = out_last_reg;
    assign sound_level = out_lvl_reg;
    assign out_valid   = out_valid_reg;

endmodule

### rtl/mic_gain_saturate_rms_level.sv
// Top level of the mic gain stage with block RMS level meter.
//
// Input stream: one 32-bit signed microphone sample per transfer in s_axis_tdata, with
// s_axis_tlast marking the last sample of a block. Output stream: one result per input,
// the scaled 16-bit sample and, on the transfer that closes a block (m_axis_tlast high),
// the block level 0..100. A block of 128 samples closes on its own.
// Configuration: cfg_wen with cfg_index 0 writes the shift amount (0..24), index 1 the
// Q2.14 gain (0..32768); other values are ignored. Write only while the block is idle.
// Timing: one item at a time. A sample that does not close a block goes through the
// scale, saturate, square and accumulate steps into the output register before the next
// sample is taken. A closing sample adds a set-up step and a level search for level L,
// one level per step and at most level 100, set by the incremental threshold compare.
// Reset clears the sum, the count and the output valid, and loads shift 8, gain 3277.
// When the receiver stalls, the result waits in the output register; the next sample
// is still taken and worked through, then holds until the output register frees.
module mic_gain_saturate_rms_level
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] mic_sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] pcm_sample, [22:16] sound_level, [23] zero
    output logic        m_axis_tlast,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import mgsrl_pkg::*;

    ctrl_cmd_t               cmd;
    ctrl_stat_t              stat;
    logic signed [PCM_W-1:0] pcm_sample;
    logic [LEVEL_W-1:0]      sound_level;

    mgsrl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    mgsrl_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mic_sample  ($signed(s_axis_tdata)),
        .block_end   (s_axis_tlast),
        .pcm_sample  (pcm_sample),
        .level_valid (m_axis_tlast),
        .sound_level (sound_level),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {1'b0, sound_level, pcm_sample};

endmodule

### tb/sv/tb_mic_gain_saturate_rms_level.sv
// Testbench for the mic gain stage with block RMS level meter: scoreboard, stimulus and checks.
module tb_mic_gain_saturate_rms_level;

    import mgsrl_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 120;
    localparam int TIMEOUT_CYCLES = 400000;

    // One expected output transfer.
    typedef struct
    {
        logic [PCM_W-1:0]   pcm;
        logic               closes;
        logic [LEVEL_W-1:0] level;
    } pcm_result_t;

    // Tracks gain, shift and the running block sums, and checks each output transfer.
    class pcm_level_scoreboard;
        int                  shift_amt;
        int                  gain;
        longint unsigned     square_sum;
        int                  sample_count;
        pcm_result_t         pending_pcm[$];
        int                  fails;

        function new();
            shift_amt    = SHIFT_RESET;
            gain         = GAIN_RESET;
            square_sum   = 0;
            sample_count = 0;
            fails        = 0;
        endfunction

        // Register writes outside the legal range leave the register as it was.
        function void apply_reg(cfg_index_t idx, logic [15:0] val);
            if (idx == REG_SHIFT)
            begin
                if (val[4:0] <= SHIFT_MAX)
                    shift_amt = val[4:0];
            end
            else if (val <= GAIN_MAX)
            begin
                gain = val;
            end
        endfunction

        // Largest level whose threshold the block's mean square still reaches.
        function int block_level(longint unsigned sum, int count);
            longint unsigned thr;
            int lvl;
            lvl = 0;
            for (int l = 1; l <= LEVEL_MAX; l++)
            begin
                thr = longint'(count) * longint'(1000 * l) * longint'(1000 * l);
                if (sum < thr)
                    break;
                lvl = l;
            end
            return lvl;
        endfunction

        // Works out the result of one accepted sample and queues it.
        function void take_sample(logic [31:0] raw, logic last);
            int          x;
            longint      prod;
            longint      mag;
            int          pcm;
            pcm_result_t res;
            x    = raw;
            x    = x >>> shift_amt;
            prod = longint'(x) * longint'(gain);
            mag  = (prod < 0 ? -prod : prod) >>> GAIN_FRAC;
            if (prod < 0)
                pcm = (mag > 32768) ? -32768 : -int'(mag);
            else
                pcm = (mag > 32767) ? 32767 : int'(mag);
            square_sum   = (square_sum + longint'(pcm * pcm)) & ((64'd1 << SUM_W) - 1);
            sample_count = (sample_count + 1) & 8'hFF;
            res.pcm    = pcm[PCM_W-1:0];
            res.closes = last || (sample_count >= MAX_FRAMES);
            res.level  = '0;
            if (res.closes)
            begin
                res.level    = LEVEL_W'(block_level(square_sum, sample_count));
                square_sum   = 0;
                sample_count = 0;
            end
            pending_pcm.push_back(res);
        endfunction

        // Compares one output transfer with the oldest expected result.
        function void check_pcm(logic [23:0] data, logic last);
            pcm_result_t res;
            if (pending_pcm.size() == 0)
            begin
                $error("unexpected output transfer: pcm_sample %0d", $signed(data[15:0]));
                fails++;
                return;
            end
            res = pending_pcm.pop_front();
            if (data[15:0] !== res.pcm)
            begin
                $error("pcm_sample: expected %0d, actual %0d", $signed(res.pcm),
                       $signed(data[15:0]));
                fails++;
            end
            if (last !== res.closes)
            begin
                $error("level_valid: expected %0d, actual %0d", res.closes, last);
                fails++;
            end
            if (data[22:16] !== res.level)
            begin
                $error("sound_level: expected %0d, actual %0d", res.level, data[22:16]);
                fails++;
            end
        endfunction

        function int outstanding();
            return pending_pcm.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] mic_sample
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [15:0] pcm_sample, [22:16] sound_level, [23] zero
    logic        m_axis_tlast;
    logic        cfg_wen       = 1'b0;
    logic        cfg_index     = 1'b0;
    logic [15:0] cfg_data      = '0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int recv_hold_left = 0;

    pcm_level_scoreboard sb = new();

    mic_gain_saturate_rms_level i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (recv_hold_left > 0)
            begin
                recv_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Output monitor: every completed transfer goes to the scoreboard.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pcm(m_axis_tdata, m_axis_tlast);
        end
    end

    // Offers one sample, with random idle cycles first, and waits for its transfer.
    task automatic send_sample(input logic [31:0] raw, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_sample(raw, last);
    endtask

    // Stops offering and waits until every expected result has come out.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; only issued while the block is idle.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.apply_reg(idx, val);
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Gain and shift for one stretch of random traffic; some stretches add rejected writes.
    task automatic pick_setting(input int part);
        int          shift_val;
        logic [15:0] gain_val;
        logic [15:0] junk;
        junk = 16'($urandom());
        case (part)
            0: shift_val = 0;
            1: shift_val = SHIFT_MAX;
            default: shift_val = $urandom_range(0, SHIFT_MAX);
        endcase
        case ($urandom_range(0, 3))
            0: gain_val = 16'd0;
            1: gain_val = 16'(GAIN_MAX);
            2: gain_val = 16'd16384;
            default: gain_val = 16'($urandom_range(0, GAIN_MAX));
        endcase
        // Upper data bits of a shift write are don't-care.
        write_reg(REG_SHIFT, {junk[15:5], shift_val[4:0]});
        write_reg(REG_GAIN, gain_val);
        if ($urandom_range(0, 1) == 1)
        begin
            write_reg(REG_SHIFT, {junk[10:0], 5'($urandom_range(SHIFT_MAX + 1, 31))});
            write_reg(REG_GAIN, 16'($urandom_range(GAIN_MAX + 1, 65535)));
        end
    endtask

    // Block lengths: mostly short, some near the frame limit, some past it.
    function automatic int pick_block_length();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return $urandom_range(1, 20);
        else if (k < 8)
            return $urandom_range(21, 60);
        else if (k == 8)
            return $urandom_range(120, 135);
        return 200;
    endfunction

    // Random traffic in three stretches, each under its own gain and shift.
    task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct,
                                    input bit long_hold);
        int raw;
        int blk_len;
        int blk_pos;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int part = 0; part < 3; part++)
        begin
            pick_setting(part);
            blk_pos = 0;
            blk_len = pick_block_length();
            for (int i = 0; i < n_items / 3; i++)
            begin
                raw = $urandom();
                raw = raw >>> $urandom_range(0, 31);
                blk_pos++;
                if (long_hold && part == 1 && i == 10)
                    recv_hold_left = 300;
                send_sample(raw, blk_pos == blk_len);
                if (blk_pos == blk_len)
                begin
                    blk_pos = 0;
                    blk_len = pick_block_length();
                end
            end
            drain_results();
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset gain and shift: field extremes, closing on a small sample.
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0100, 1'b1);
        drain_results();

        // Largest gain with no shift: saturation on both sides and the exact negative limit.
        write_reg(REG_SHIFT, 16'd0);
        write_reg(REG_GAIN, 16'(GAIN_MAX));
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h0000_4000, 1'b0);
        send_sample(32'hFFFF_C000, 1'b0);
        send_sample(32'h0000_3FFF, 1'b1);
        drain_results();

        // Out-of-range writes are dropped; the shift write keeps only its low bits.
        write_reg(REG_GAIN, 16'd16384);
        write_reg(REG_SHIFT, 16'hFFF8);
        write_reg(REG_SHIFT, 16'd25);
        write_reg(REG_GAIN, 16'd40000);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        drain_results();

        // Zero gain silences everything.
        write_reg(REG_GAIN, 16'd0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        drain_results();

        // Truncation toward zero on a negative product, then a loud block.
        write_reg(REG_SHIFT, 16'd0);
        write_reg(REG_GAIN, 16'd16383);
        send_sample(32'hFFFF_FFFD, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        drain_results();

        run_random_phase(234, 21, 70, 1'b0);
        run_random_phase(234, 70, 21, 1'b0);
        run_random_phase(234, 0, 0, 1'b1);

        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
